>>> hdl/stba_pkg.sv
// Shared types, constants and helpers for the smootherstep tile blend accumulator.
// No dependencies.
package stba_pkg;

   localparam int ImgW   = 256;
   localparam int ImgH   = 256;
   localparam int Planes = 4;
   localparam int XW     = $clog2(ImgW);
   localparam int YW     = $clog2(ImgH);
   localparam int PW     = $clog2(Planes);
   localparam int AddrW  = PW + YW + XW;
   localparam int Depth  = Planes * ImgW * ImgH;

   localparam logic [16:0] One = 17'h10000;

   localparam logic [2:0] RegImgW  = 3'd0;
   localparam logic [2:0] RegImgH  = 3'd1;
   localparam logic [2:0] RegTileW = 3'd2;
   localparam logic [2:0] RegTileH = 3'd3;
   localparam logic [2:0] RegOvX   = 3'd4;
   localparam logic [2:0] RegOvY   = 3'd5;
   localparam logic [2:0] RegWrap  = 3'd6;

   localparam logic OpBlend = 1'b0;
   localparam logic OpRead  = 1'b1;

   typedef struct packed {
      logic               valid;
      logic               op;
      logic               skip;
      logic               repl;
      logic [1:0]         plane;
      logic [8:0]         ax;
      logic [8:0]         ay;
      logic signed [31:0] smp;
   } ctl_type;

   // Partial modulo: restoring subtract steps hi down to lo.
   function automatic logic [8:0] wrap_steps(input logic [8:0] v, input logic [8:0] m,
                                             input int hi, input int lo);
      logic [17:0] r;
      logic [17:0] d;
      r = {9'd0, v};
      for (int k = 8; k >= 0; k--) begin
         d = {9'd0, m} << k;
         if (k <= hi && k >= lo && r >= d) begin
            r = r - d;
         end
      end
      return r[8:0];
   endfunction

   function automatic logic [AddrW-1:0] addr_of(input ctl_type c);
      return {c.plane[PW-1:0], c.ay[YW-1:0], c.ax[XW-1:0]};
   endfunction

endpackage

>>> hdl/stba_axis.sv
// One axis edge weight: ramp select, pipelined fraction divider, smootherstep.
// Depends on stba_pkg. Nine register stages, all advanced by en.
module stba_axis import stba_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [7:0]  pos,
   input  logic [7:0]  skip,
   input  logic [7:0]  origin,
   input  logic [8:0]  tile,
   input  logic [8:0]  img,
   input  logic [7:0]  ov,
   input  logic        circ,
   output logic [16:0] weight
);

   logic signed [10:0] n0, n1, lim, m, ovs;
   logic               use0, use1, full_in, zero_in;

   logic [7:0]  rem_ff  [0:4];
   logic [15:0] q_ff    [0:4];
   logic [7:0]  ovd_ff  [0:4];
   logic        full_ff [0:4];
   logic        zero_ff [0:4];

   logic [7:0]  rem_in  [1:4];
   logic [15:0] q_in    [1:4];

   logic [16:0] t_in, t_b1_ff, t2, t3;
   logic [33:0] tsq_ff, t3p_ff;
   logic [35:0] six;
   logic [21:0] p_in;
   logic [19:0] p16_ff;
   logic [36:0] s_ff;
   logic [20:0] s_sh;
   logic [16:0] weight_ff;

   // Pick the nearer ramp; a disabled side never wins the minimum.
   always_comb begin
      n0   = $signed({3'b0, pos}) - $signed({3'b0, skip});
      n1   = $signed({2'b0, tile}) - $signed({3'b0, pos});
      lim  = $signed({2'b0, img}) - $signed({2'b0, tile});
      use0 = circ || (origin != 8'd0);
      use1 = circ || ($signed({3'b0, origin}) < lim);
      m    = 11'sd512;
      if (use0) begin
         m = n0;
      end
      if (use1 && n1 < m) begin
         m = n1;
      end
      ovs     = $signed({3'b0, ov});
      full_in = (ov == 8'd0) || (m >= ovs);
      zero_in = !full_in && (m <= 11'sd0);
   end

   // Four quotient bits per stage.
   always_comb begin
      logic [8:0]  r2;
      logic [7:0]  r;
      logic [15:0] q;
      for (int s = 1; s <= 4; s++) begin
         r = rem_ff[s-1];
         q = q_ff[s-1];
         for (int i = 0; i < 4; i++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, ovd_ff[s-1]}) begin
               r2 = r2 - {1'b0, ovd_ff[s-1]};
               q  = {q[14:0], 1'b1};
            end else begin
               q  = {q[14:0], 1'b0};
            end
            r = r2[7:0];
         end
         rem_in[s] = r;
         q_in[s]   = q;
      end
   end

   always_comb begin
      t_in = full_ff[4] ? One : (zero_ff[4] ? 17'd0 : {1'b0, q_ff[4]});
      t2   = tsq_ff[32:16];
      t3   = t3p_ff[32:16];
      six  = ({2'b0, tsq_ff} << 2) + ({2'b0, tsq_ff} << 1);
      p_in = {2'b0, six[35:16]} + 22'd655360 - (({5'b0, t_b1_ff} << 4) - {5'b0, t_b1_ff});
      s_sh = s_ff[36:16];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= m[7:0];
         q_ff[0]    <= '0;
         ovd_ff[0]  <= ov;
         full_ff[0] <= full_in;
         zero_ff[0] <= zero_in;
         for (int s = 1; s <= 4; s++) begin
            rem_ff[s]  <= rem_in[s];
            q_ff[s]    <= q_in[s];
            ovd_ff[s]  <= ovd_ff[s-1];
            full_ff[s] <= full_ff[s-1];
            zero_ff[s] <= zero_ff[s-1];
         end
         t_b1_ff   <= t_in;
         tsq_ff    <= t_in * t_in;
         t3p_ff    <= t2 * t_b1_ff;
         p16_ff    <= p_in[19:0];
         s_ff      <= t3 * p16_ff;
         weight_ff <= (s_sh > {4'b0, One}) ? One : s_sh[16:0];
      end
   end

   assign weight = weight_ff;

endmodule

>>> hdl/stba_accum.sv
// Image store with clearing pass, write forwarding and the blend/read/replace stage.
// Depends on stba_pkg.
module stba_accum import stba_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  ctl_type            rd_ctl,
   input  ctl_type            a_ctl,
   input  logic signed [49:0] prod,
   output logic               clr_done,
   output logic [31:0]        res,
   output logic               sat,
   output logic               skp
);

   logic [31:0]       mem [Depth];
   logic [31:0]       rd_data_ff;
   logic [AddrW-1:0]  clr_cnt_ff, a_addr, fwd_addr_ff;
   logic              clr_done_ff, fwd_valid_ff, wr_en;
   logic [31:0]       fwd_data_ff, old, wr_data;
   logic signed [33:0] contrib, sum;

   assign a_addr = addr_of(a_ctl);

   always_comb begin
      old = (fwd_valid_ff && fwd_addr_ff == a_addr) ? fwd_data_ff : rd_data_ff;
      contrib = prod[49:16];
      if (prod[49] && prod[15:0] != 16'd0) begin
         contrib = contrib + 34'sd1;
      end
      sum = $signed({{2{old[31]}}, old}) + contrib;
      res = '0;
      sat = 1'b0;
      skp = 1'b0;
      wr_data = '0;
      if (a_ctl.op == OpRead) begin
         res = old;
      end else if (a_ctl.skip) begin
         skp = 1'b1;
      end else if (a_ctl.repl) begin
         res = a_ctl.smp;
         wr_data = a_ctl.smp;
      end else begin
         if (sum > 34'sh0_7FFF_FFFF) begin
            res = 32'h7FFF_FFFF;
            sat = 1'b1;
         end else if (sum < -34'sh0_8000_0000) begin
            res = 32'h8000_0000;
            sat = 1'b1;
         end else begin
            res = sum[31:0];
         end
         wr_data = res;
      end
      wr_en = en && a_ctl.valid && clr_done_ff && (a_ctl.op == OpRead || !a_ctl.skip);
   end

   always_ff @(posedge clock) begin
      if (!clr_done_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         mem[a_addr] <= wr_data;
      end
      if (en) begin
         rd_data_ff <= mem[addr_of(rd_ctl)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         clr_done_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (!clr_done_ff) begin
            clr_cnt_ff <= clr_cnt_ff + AddrW'(1);
            if (clr_cnt_ff == AddrW'(Depth - 1)) begin
               clr_done_ff <= 1'b1;
            end
         end
         if (en) begin
            fwd_valid_ff <= wr_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fwd_addr_ff <= a_addr;
         fwd_data_ff <= wr_data;
      end
   end

   assign clr_done = clr_done_ff;

endmodule

>>> hdl/smootherstep_tile_blend_accumulator.sv
// Top level of the smootherstep tile blend accumulator.
// Depends on stba_pkg, stba_axis and stba_accum.
//
// Usage:
//  - req_* channel (valid/ready): one item per cycle while req_ready is high, either
//    a tile sample to blend into the image store (op blend) or a read-and-clear of
//    one entry (op read).
//  - rsp_* channel (valid/ready): exactly one result item per request item, in order.
//  - csr_* port: plain register writes, to be made only while the block is idle; the
//    user must keep to this, as the block itself does not enforce it.
//  - Throughput: one item per cycle while req_ready is high. The 12-stage pipeline
//    (address wrap in two stages, ramp divider in four, smootherstep in four, weight
//    product, sample product, store read-modify-write last) feeds the output register.
//  - The store is one memory of 262144 words with one write and one read port; a
//    write from the last stage is forwarded to the next item reading the same entry.
//  - Reset: the registers take their reset values and a clearing pass zeroes the
//    store one entry per cycle, all 262144 entries, with req_ready low meanwhile.
//  - Receiver stall: the whole pipeline holds while the output register is full and
//    rsp_ready is low; nothing is lost or repeated.
module smootherstep_tile_blend_accumulator import stba_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [1:0]         req_plane,
   input  logic [7:0]         req_col,
   input  logic [7:0]         req_row,
   input  logic [7:0]         req_origin_x,
   input  logic [7:0]         req_origin_y,
   input  logic [7:0]         req_skip_x,
   input  logic [7:0]         req_skip_y,
   input  logic signed [31:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_stored_value,
   output logic               rsp_saturated,
   output logic               rsp_skipped,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [8:0]         csr_wdata
);

   // configuration registers
   logic [8:0] img_w_ff, img_h_ff, tile_w_ff, tile_h_ff, w_eff, h_eff;
   logic [7:0] ov_x_ff, ov_y_ff;
   logic [1:0] wrap_ff;

   // pipeline
   ctl_type     ctl_ff [1:12];
   ctl_type     ctl_in [1:12];
   logic [7:0]  col_ff, row_ff, ox_ff, oy_ff, sx_ff, sy_ff;
   logic [16:0] wx, wy, wt_ff;
   logic [33:0] wxy;
   logic signed [49:0] prod_ff;
   logic        en, clr_done;

   logic [31:0] a_res;
   logic        a_sat, a_skp;

   logic        rsp_valid_ff, rsp_sat_ff, rsp_skp_ff;
   logic [31:0] rsp_value_ff;

   // Advance everything when the output register is free or being drained.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en && clr_done;

   always_comb begin
      w_eff = (img_w_ff == 9'd0) ? 9'd1 : ((img_w_ff > 9'(ImgW)) ? 9'(ImgW) : img_w_ff);
      h_eff = (img_h_ff == 9'd0) ? 9'd1 : ((img_h_ff > 9'(ImgH)) ? 9'(ImgH) : img_h_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff  <= 9'd256;
         img_h_ff  <= 9'd256;
         tile_w_ff <= 9'd64;
         tile_h_ff <= 9'd64;
         ov_x_ff   <= 8'd16;
         ov_y_ff   <= 8'd16;
         wrap_ff   <= 2'd0;
      end else if (csr_we) begin
         case (csr_index)
            RegImgW:  img_w_ff  <= csr_wdata;
            RegImgH:  img_h_ff  <= csr_wdata;
            RegTileW: tile_w_ff <= csr_wdata;
            RegTileH: tile_h_ff <= csr_wdata;
            RegOvX:   ov_x_ff   <= csr_wdata[7:0];
            RegOvY:   ov_y_ff   <= csr_wdata[7:0];
            RegWrap:  wrap_ff   <= csr_wdata[1:0];
            default:  ;
         endcase
      end
   end

   // Stage inputs: entry stage builds flags and raw wrap sums; stages 2 and 3 finish
   // the modulo; the rest just carry the item along.
   always_comb begin
      ctl_in[1].valid = req_valid && clr_done;
      ctl_in[1].op    = req_op;
      ctl_in[1].skip  = ({1'b0, req_col} >= tile_w_ff) || ({1'b0, req_row} >= tile_h_ff) ||
                        (req_col < req_skip_x) || (req_row < req_skip_y);
      ctl_in[1].repl  = (ov_x_ff == 8'd0) && (ov_y_ff == 8'd0);
      ctl_in[1].plane = req_plane;
      ctl_in[1].ax    = {1'b0, req_origin_x} + {1'b0, req_col};
      ctl_in[1].ay    = {1'b0, req_origin_y} + {1'b0, req_row};
      ctl_in[1].smp   = req_sample;
      for (int k = 2; k <= 12; k++) begin
         ctl_in[k] = ctl_ff[k-1];
      end
      ctl_in[2].ax = wrap_steps(ctl_ff[1].ax, w_eff, 8, 4);
      ctl_in[2].ay = wrap_steps(ctl_ff[1].ay, h_eff, 8, 4);
      ctl_in[3].ax = wrap_steps(ctl_ff[2].ax, w_eff, 3, 0);
      ctl_in[3].ay = wrap_steps(ctl_ff[2].ay, h_eff, 3, 0);
   end

   // Valid bits clear at reset; payload advances with en.
   always_ff @(posedge clock) begin
      for (int k = 1; k <= 12; k++) begin
         if (reset) begin
            ctl_ff[k].valid <= 1'b0;
         end else if (en) begin
            ctl_ff[k].valid <= ctl_in[k].valid;
         end
         if (en) begin
            ctl_ff[k].op    <= ctl_in[k].op;
            ctl_ff[k].skip  <= ctl_in[k].skip;
            ctl_ff[k].repl  <= ctl_in[k].repl;
            ctl_ff[k].plane <= ctl_in[k].plane;
            ctl_ff[k].ax    <= ctl_in[k].ax;
            ctl_ff[k].ay    <= ctl_in[k].ay;
            ctl_ff[k].smp   <= ctl_in[k].smp;
         end
      end
      if (en) begin
         col_ff <= req_col;
         row_ff <= req_row;
         ox_ff  <= req_origin_x;
         oy_ff  <= req_origin_y;
         sx_ff  <= req_skip_x;
         sy_ff  <= req_skip_y;
      end
   end

   // Axis weights come out aligned with stage 10.
   stba_axis u_axis_x (
      .clock  (clock),
      .en     (en),
      .pos    (col_ff),
      .skip   (sx_ff),
      .origin (ox_ff),
      .tile   (tile_w_ff),
      .img    (w_eff),
      .ov     (ov_x_ff),
      .circ   (wrap_ff[0]),
      .weight (wx)
   );

   stba_axis u_axis_y (
      .clock  (clock),
      .en     (en),
      .pos    (row_ff),
      .skip   (sy_ff),
      .origin (oy_ff),
      .tile   (tile_h_ff),
      .img    (h_eff),
      .ov     (ov_y_ff),
      .circ   (wrap_ff[1]),
      .weight (wy)
   );

   assign wxy = wx * wy;

   // Stage 11 combined weight, stage 12 weighted sample.
   always_ff @(posedge clock) begin
      if (en) begin
         wt_ff   <= wxy[32:16];
         prod_ff <= ctl_ff[11].smp * $signed({1'b0, wt_ff});
      end
   end

   stba_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .rd_ctl   (ctl_ff[11]),
      .a_ctl    (ctl_ff[12]),
      .prod     (prod_ff),
      .clr_done (clr_done),
      .res      (a_res),
      .sat      (a_sat),
      .skp      (a_skp)
   );

   // Output register: hold while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl_ff[12].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_value_ff <= a_res;
         rsp_sat_ff   <= a_sat;
         rsp_skp_ff   <= a_skp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_stored_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_skipped      = rsp_skp_ff;

   // No item enters while the store is still being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[1].valid |-> $past(clr_done))
      else $error("item accepted during clearing pass");

   // A skipped sample never reports saturation and always reports zero.
   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_skipped |-> !rsp_saturated && rsp_stored_value == 32'd0)
      else $error("skipped result carries data");

   // A stalled last stage keeps its item.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[12].valid && !en |=> ctl_ff[12].valid)
      else $error("last stage dropped an item during stall");

endmodule

>>> tb/smootherstep_tile_blend_accumulator_tb.sv
// Testbench for the smootherstep tile blend accumulator: directed and random items
// checked against a built-in predictor of the image store. Depends on stba_pkg.
module smootherstep_tile_blend_accumulator_tb;
   import stba_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_op = 1'b0;
   logic [1:0]         req_plane = '0;
   logic [7:0]         req_col = '0, req_row = '0;
   logic [7:0]         req_origin_x = '0, req_origin_y = '0;
   logic [7:0]         req_skip_x = '0, req_skip_y = '0;
   logic signed [31:0] req_sample = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_stored_value;
   logic               rsp_saturated, rsp_skipped;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [8:0]         csr_wdata = '0;

   typedef struct packed {
      logic signed [31:0] value;
      logic               sat;
      logic               skp;
   } blend_result_type;

   blend_result_type expected_q[$];
   logic signed [31:0] image_model [0:Depth-1];
   int unsigned img_w, img_h, tile_w, tile_h, ov_x, ov_y, wrap;
   int errors = 0;
   int idle_cycles = 0;
   bit gaps_on = 1'b1;
   localparam int IdleLimit = 1000000;

   smootherstep_tile_blend_accumulator u_dut (.*);

   always #5 clock = ~clock;

   // Mostly no gap or a short one, now and then a long one.
   function automatic int gap_len();
      if (!gaps_on) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   function automatic longint ramp_q16(longint num, longint ov);
      longint t;
      if (num <= 0) return 0;
      t = (num * 65536) / ov;
      return (t > 65536) ? 65536 : t;
   endfunction

   function automatic longint smoother_q16(longint t);
      longint p, t2, t3, s;
      p  = 6 * t * t + 10 * (longint'(1) << 32) - 15 * 65536 * t;
      t2 = (t * t) >>> 16;
      t3 = (t2 * t) >>> 16;
      s  = (t3 * (p >>> 16)) >>> 16;
      return (s > 65536) ? 65536 : s;
   endfunction

   function automatic longint edge_weight(longint pos, longint skp, longint tile,
                                          longint ov, bit circ, longint org, longint img);
      longint w0, w1;
      w0 = 65536;
      w1 = 65536;
      if (ov == 0) return 65536;
      if (circ || org > 0) w0 = ramp_q16(pos - skp, ov);
      if (circ || org < img - tile) w1 = ramp_q16(tile - pos, ov);
      return (w0 < w1) ? w0 : w1;
   endfunction

   // Update the store model for one item and return what the block should answer.
   function automatic blend_result_type predict_blend(bit op, logic [1:0] pl, int col,
         int row, int ox, int oy, int sx, int sy, logic signed [31:0] smp);
      blend_result_type r;
      longint w, h, ax, ay, old, wx, wy, wt, contrib, sum;
      int addr;
      r = '0;
      w = (img_w < 1) ? 1 : (img_w > ImgW ? ImgW : img_w);
      h = (img_h < 1) ? 1 : (img_h > ImgH ? ImgH : img_h);
      ax = (ox + col) % w;
      ay = (oy + row) % h;
      addr = int'(pl) * ImgW * ImgH + int'(ay) * ImgW + int'(ax);
      old = image_model[addr];
      if (op == OpRead) begin
         r.value = old[31:0];
         image_model[addr] = 0;
      end else if (col < sx || row < sy || col >= tile_w || row >= tile_h) begin
         r.skp = 1'b1;
      end else if (ov_x == 0 && ov_y == 0) begin
         r.value = smp;
         image_model[addr] = smp;
      end else begin
         wx = smoother_q16(edge_weight(col, sx, tile_w, ov_x, wrap[0], ox, w));
         wy = smoother_q16(edge_weight(row, sy, tile_h, ov_y, wrap[1], oy, h));
         wt = (wx * wy) >>> 16;
         contrib = (longint'(smp) * wt) / 65536;
         sum = old + contrib;
         if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            r.sat = 1'b1;
         end
         if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            r.sat = 1'b1;
         end
         r.value = sum[31:0];
         image_model[addr] = sum[31:0];
      end
      return r;
   endfunction

   // Send one item; drop valid only for a gap, hold valid and payload until accepted.
   task automatic send_item(bit op, logic [1:0] pl, logic [7:0] col, logic [7:0] row,
         logic [7:0] ox, logic [7:0] oy, logic [7:0] sx, logic [7:0] sy,
         logic signed [31:0] smp);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_plane    <= pl;
      req_col      <= col;
      req_row      <= row;
      req_origin_x <= ox;
      req_origin_y <= oy;
      req_skip_x   <= sx;
      req_skip_y   <= sy;
      req_sample   <= smp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_q.push_back(predict_blend(op, pl, col, row, ox, oy, sx, sy, smp));
   endtask

   // Write one register, enable raised; the caller drops it after the last write.
   task automatic write_reg(logic [2:0] idx, int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[8:0];
      @(posedge clock);
      case (idx)
         RegImgW:  img_w  = val & 9'h1FF;
         RegImgH:  img_h  = val & 9'h1FF;
         RegTileW: tile_w = val & 9'h1FF;
         RegTileH: tile_h = val & 9'h1FF;
         RegOvX:   ov_x   = val & 8'hFF;
         RegOvY:   ov_y   = val & 8'hFF;
         RegWrap:  wrap   = val & 2'h3;
         default:  ;
      endcase
   endtask

   // Drain all results and let the pipeline settle before touching registers.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_config(int unsigned w, int unsigned h, int unsigned tw,
         int unsigned th, int unsigned ox, int unsigned oy, int unsigned wm);
      wait_idle();
      write_reg(RegImgW, w);
      write_reg(RegImgH, h);
      write_reg(RegTileW, tw);
      write_reg(RegTileH, th);
      write_reg(RegOvX, ox);
      write_reg(RegOvY, oy);
      write_reg(RegWrap, wm);
      csr_we <= 1'b0;
   endtask

   task automatic random_blend(int unsigned maxc);
      send_item(OpBlend, 2'($urandom), 8'($urandom_range(0, maxc)),
                8'($urandom_range(0, maxc)), 8'($urandom), 8'($urandom),
                8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)), 32'($urandom));
   endtask

   // Extremes of every field, replace mode, skips, saturation and read-back.
   task automatic test_directed();
      set_config(256, 256, 64, 64, 0, 0, 0);
      send_item(OpBlend, 2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'sh7FFFFFFF);
      send_item(OpBlend, 2'd3, 8'd63, 8'd63, 8'd255, 8'd255, 8'd0, 8'd0, 32'sh80000000);
      send_item(OpBlend, 2'd1, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'sd5);
      send_item(OpBlend, 2'd1, 8'd2, 8'd2, 8'd0, 8'd0, 8'd255, 8'd255, 32'sd5);
      send_item(OpRead,  2'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'sd0);
      send_item(OpRead,  2'd3, 8'd63, 8'd63, 8'd255, 8'd255, 8'd0, 8'd0, 32'sd0);
      set_config(256, 256, 64, 64, 16, 16, 0);
      send_item(OpBlend, 2'd2, 8'd32, 8'd32, 8'd10, 8'd10, 8'd0, 8'd0, 32'sh7FFFFFFF);
      send_item(OpBlend, 2'd2, 8'd32, 8'd32, 8'd10, 8'd10, 8'd0, 8'd0, 32'sh7FFFFFFF);
      send_item(OpBlend, 2'd2, 8'd5, 8'd40, 8'd10, 8'd10, 8'd2, 8'd0, 32'sh80000000);
      send_item(OpBlend, 2'd2, 8'd5, 8'd40, 8'd10, 8'd10, 8'd2, 8'd0, 32'sh80000000);
      send_item(OpBlend, 2'd2, 8'd5, 8'd40, 8'd10, 8'd10, 8'd2, 8'd0, 32'sh80000000);
      send_item(OpRead,  2'd2, 8'd32, 8'd32, 8'd10, 8'd10, 8'd0, 8'd0, 32'sd0);
      // circular axes; the x axis with zero overlap counts as full weight
      set_config(1, 256, 256, 256, 0, 255, 3);
      send_item(OpBlend, 2'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd0, 8'd0, 32'sh00010000);
      send_item(OpRead,  2'd0, 8'd7, 8'd128, 8'd3, 8'd0, 8'd0, 8'd0, 32'sd0);
      // zero tile size skips every sample
      set_config(256, 1, 0, 0, 1, 1, 0);
      send_item(OpBlend, 2'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'sd99);
   endtask

   task automatic test_random();
      int cfg;
      for (cfg = 0; cfg < 8; cfg++) begin
         case (cfg)
            0: set_config(256, 256, 64, 64, 16, 16, 0);
            1: set_config(32, 16, 24, 20, 8, 4, 1);
            2: set_config(8, 8, 16, 16, 255, 255, 3);
            3: set_config(511, 300, 256, 256, 1, 0, 2);
            4: set_config(20, 20, 20, 20, 0, 0, 0);
            default: set_config($urandom_range(1, 256), $urandom_range(1, 256),
                                $urandom_range(1, 80), $urandom_range(1, 80),
                                $urandom_range(0, 40), $urandom_range(0, 40),
                                $urandom_range(0, 3));
         endcase
         gaps_on = (cfg != 2);
         repeat (80) begin
            if ($urandom_range(0, 4) == 0) begin
               send_item(OpRead, 2'($urandom), 8'($urandom_range(0, 40)),
                         8'($urandom_range(0, 40)), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 32'($urandom));
            end else if ($urandom_range(0, 9) == 0) begin
               send_item(OpBlend, 2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom), 32'($urandom));
            end else begin
               random_blend(40);
            end
         end
         gaps_on = 1'b1;
      end
   endtask

   // Check each result against the oldest prediction.
   always @(posedge clock) begin
      blend_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected item value=%0d", $time, rsp_stored_value);
            errors++;
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_stored_value !== exp_r.value || rsp_saturated !== exp_r.sat ||
                rsp_skipped !== exp_r.skp) begin
               $display("%0t: expected %0d sat %0b skip %0b, actual %0d sat %0b skip %0b",
                        $time, exp_r.value, exp_r.sat, exp_r.skp,
                        rsp_stored_value, rsp_saturated, rsp_skipped);
               errors++;
            end
         end
      end
   end

   // Stall the receiver at random.
   always @(posedge clock) begin
      if (!gaps_on) rsp_ready <= 1'b1;
      else if ($urandom_range(0, 29) == 0) rsp_ready <= 1'b0;
      else if ($urandom_range(0, 2) != 0) rsp_ready <= 1'b1;
   end

   // Watchdog: count cycles with no handshake; covers the clearing pass after reset.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < Depth; i++) image_model[i] = 0;
      img_w = 256; img_h = 256; tile_w = 64; tile_h = 64;
      ov_x = 16; ov_y = 16; wrap = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
